@@ sv/go_to_point_navigation_controller_defines.svh @@
// Assertion macros shared by the checker
`ifndef GO_TO_POINT_NAVIGATION_CONTROLLER_DEFINES_SVH
`define GO_TO_POINT_NAVIGATION_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define GTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtp assertion failed");

// next-cycle implication
`define GTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtp assertion failed");

`endif

@@ sv/gtp_pkg.sv @@
package gtp_pkg;

  // parameter defaults
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int ID_WIDTH_DEF     = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // fixed field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int SPEED_W    = 7;
  localparam int DTHR_W     = 12;
  localparam int HTHR_W     = 15;
  localparam int ITER_W     = 5;
  localparam int ZW         = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOC_PRESENT = 3'd0,
    CFG_DIST_THR    = 3'd1,
    CFG_STOP_THR    = 3'd2,
    CFG_TURN_THR    = 3'd3,
    CFG_MOVE_SPD    = 3'd4,
    CFG_TURN_SPD    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FUNC_GOTO  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_TURN = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } loc_req_t;

  typedef enum logic [2:0] {
    PH_WAIT_CMD    = 3'd0,
    PH_REQ_BEFORE  = 3'd1,
    PH_WAIT_BEFORE = 3'd2,
    PH_GOTO        = 3'd3,
    PH_REQ_AFTER   = 3'd4,
    PH_WAIT_AFTER  = 3'd5,
    PH_FINISH      = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_INIT,
    S_ROT,
    S_ERR,
    S_SCALE,
    S_RES
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              square;
    logic              init;
    logic              rotate;
    logic              error;
    logic              scale;
    logic              commit;
    logic [ITER_W-1:0] iter;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [ZW-1:0] atan_val(input logic [ITER_W-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/gtp_if.sv @@
// Input item channel
interface gtp_in_if #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;
  logic signed [ANGLE_WIDTH-1:0] target_heading;
  logic signed [COORD_WIDTH-1:0] pose_x;
  logic signed [COORD_WIDTH-1:0] pose_y;
  logic signed [ANGLE_WIDTH-1:0] pose_heading;

  modport source (output valid, func, target_x, target_y, target_heading,
                  pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, func, target_x, target_y, target_heading,
                pose_x, pose_y, pose_heading, output ready);
endinterface

// Result item channel
interface gtp_out_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] cmd_id;
  logic [1:0]          action;
  logic signed [7:0]   left_speed;
  logic signed [7:0]   right_speed;
  logic [1:0]          localize_request;
  logic                granted;
  logic                finished;

  modport source (output valid, cmd_id, action, left_speed, right_speed,
                  localize_request, granted, finished, input ready);
  modport sink (input valid, cmd_id, action, left_speed, right_speed,
                localize_request, granted, finished, output ready);
endinterface

// Configuration write channel
interface gtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/gtp_ctrl.sv @@
module gtp_ctrl
  import gtp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  ctl_state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;

  // state and iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SQR;
      S_SQR:   state_nxt = S_INIT;
      S_INIT: begin
        state_nxt = S_ROT;
        cnt_nxt   = '0;
      end
      S_ROT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = S_ERR;
      end
      S_ERR:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_RES;
      S_RES:   if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.iter   = ITER_W'(cnt_r);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SQR:   cmd.square = 1'b1;
      S_INIT:  cmd.init   = 1'b1;
      S_ROT:   cmd.rotate = 1'b1;
      S_ERR:   cmd.error  = 1'b1;
      S_SCALE: cmd.scale  = 1'b1;
      S_RES:   cmd.commit = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ sv/gtp_datapath.sv @@
module gtp_datapath
  import gtp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_func,
  input  logic signed [COORD_WIDTH-1:0] in_target_x,
  input  logic signed [COORD_WIDTH-1:0] in_target_y,
  input  logic signed [ANGLE_WIDTH-1:0] in_target_heading,
  input  logic signed [COORD_WIDTH-1:0] in_pose_x,
  input  logic signed [COORD_WIDTH-1:0] in_pose_y,
  input  logic signed [ANGLE_WIDTH-1:0] in_pose_heading,
  gtp_cfg_if.sink                       cfg_if,
  gtp_out_if.source                     out_if,
  input  ctl_cmd_t                      cmd,
  output dp_status_t                    status
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = ANGLE_WIDTH;
  localparam int DW   = CW + 1;
  localparam int XW   = CW + 4;
  localparam int QW   = AW - 2;
  localparam int CMPW = ((AW > HTHR_W) ? AW : HTHR_W) + 1;
  localparam logic [QW-1:0] EIGHTH = QW'(1) << (AW - 3);
  localparam logic [QW-1:0] HALF_EIGHTH = QW'(1) << (AW - 4);
  localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);
  localparam logic [ZW-1:0] RND = ZW'(1) << (31 - AW);
  localparam logic [ZW-1:0] Z_QUARTER = ZW'(1) << 30;

  // configuration registers
  logic              loc_present_r;
  logic [DTHR_W-1:0] dist_thr_r;
  logic [HTHR_W-1:0] stop_thr_r, turn_thr_r;
  logic [SPEED_W-1:0] move_spd_r, turn_spd_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_present_r <= 1'b0;
      dist_thr_r    <= 12'd10;
      stop_thr_r    <= 15'd1820;
      turn_thr_r    <= 15'd5461;
      move_spd_r    <= 7'd12;
      turn_spd_r    <= 7'd12;
    end else if (cfg_if.valid) begin
      case (cfg_idx_t'(cfg_if.index))
        CFG_LOC_PRESENT: loc_present_r <= cfg_if.data[0];
        CFG_DIST_THR:    dist_thr_r    <= cfg_if.data[DTHR_W-1:0];
        CFG_STOP_THR:    stop_thr_r    <= cfg_if.data[HTHR_W-1:0];
        CFG_TURN_THR:    turn_thr_r    <= cfg_if.data[HTHR_W-1:0];
        CFG_MOVE_SPD:    move_spd_r    <= cfg_if.data[SPEED_W-1:0];
        CFG_TURN_SPD:    turn_spd_r    <= cfg_if.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_t               phase_r, phase_nxt;
  logic                 loc_flag_r, loc_flag_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic signed [CW-1:0] pend_x_r, pend_y_r, act_x_r, act_y_r;
  logic [AW-1:0]        pend_h_r, act_h_r;
  logic [ID_WIDTH-1:0]  pend_id_r, act_id_r, act_id_nxt, last_id_r, last_id_nxt;

  // latched item
  logic [1:0]           func_r;
  logic signed [CW-1:0] tx_r, ty_r;
  logic [AW-1:0]        th_r, ph_r;
  logic signed [DW-1:0] dx_r, dy_r;

  // distance test
  logic                 far_r, close_r, zero_r;
  logic [2*DTHR_W-1:0]  sqx_r, sqy_r, thr_sq_r;
  logic [DW-1:0]        adx, ady;

  // CORDIC
  logic signed [XW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;

  // heading error and speeds
  logic [AW-1:0]            head, dh_r, mag_r;
  logic [ZW-1:0]            zr;
  logic [QW-1:0]            m_sel;
  logic [SPEED_W+QW-1:0]    prod;
  logic [SPEED_W-1:0]       red;

  // output register
  logic                 out_valid_r;
  logic [ID_WIDTH-1:0]  o_id_r, o_id_nxt;
  logic [1:0]           o_act_r, o_act_nxt, o_req_r, o_req_nxt;
  logic signed [7:0]    o_ls_r, o_ls_nxt, o_rs_r, o_rs_nxt;
  logic                 o_gr_r, o_gr_nxt, o_fin_r, o_fin_nxt;

  assign status.out_free = !out_valid_r || out_if.ready;

  assign adx = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign ady = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  // CORDIC prelude: x = dy, y = dx, folded into the right half plane
  always_comb begin
    x0 = XW'(dy_r);
    y0 = XW'(dx_r);
    z0 = '0;
    if (dy_r < 0) begin
      if (dx_r >= 0) begin
        x0 = XW'(dx_r);
        y0 = -XW'(dy_r);
        z0 = Z_QUARTER;
      end else begin
        x0 = -XW'(dx_r);
        y0 = XW'(dy_r);
        z0 = -Z_QUARTER;
      end
    end
  end

  assign xs = x_r >>> cmd.iter;
  assign ys = y_r >>> cmd.iter;

  // bearing rounded to nearest at angle width
  assign zr   = z_r + RND;
  assign head = close_r ? act_h_r : (zero_r ? QUARTER : zr[ZW-1 -: AW]);

  // slowdown from the magnitude, error clamped to a sixteenth turn
  assign m_sel = (mag_r > AW'(HALF_EIGHTH)) ? HALF_EIGHTH : QW'(mag_r);
  assign prod  = SPEED_W'(move_spd_r) * (SPEED_W+QW)'(EIGHTH - m_sel) ;
  assign red   = SPEED_W'(prod >> (AW - 3));

  // datapath stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      tx_r   <= in_target_x;
      ty_r   <= in_target_y;
      th_r   <= in_target_heading;
      ph_r   <= in_pose_heading;
      dx_r   <= DW'(act_x_r) - DW'(in_pose_x);
      dy_r   <= DW'(act_y_r) - DW'(in_pose_y);
    end
    if (cmd.square) begin
      far_r    <= (33'(adx) >= 33'd4096) || (33'(ady) >= 33'd4096);
      sqx_r    <= DTHR_W'(adx) * DTHR_W'(adx);
      sqy_r    <= DTHR_W'(ady) * DTHR_W'(ady);
      thr_sq_r <= dist_thr_r * dist_thr_r;
    end
    if (cmd.init) begin
      close_r <= !far_r &&
                 ((2*DTHR_W+1)'(sqx_r) + (2*DTHR_W+1)'(sqy_r) <
                  (2*DTHR_W+1)'(thr_sq_r));
      zero_r  <= (dx_r == '0) && (dy_r == '0);
      x_r     <= x0;
      y_r     <= y0;
      z_r     <= z0;
    end
    if (cmd.rotate) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + signed'(atan_val(cmd.iter));
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - signed'(atan_val(cmd.iter));
      end
    end
    if (cmd.error) begin
      dh_r <= head - ph_r;
    end
    if (cmd.scale) begin
      mag_r <= dh_r[AW-1] ? AW'(-dh_r) : dh_r;
    end
    if (cmd.commit) begin
      o_id_r  <= o_id_nxt;
      o_act_r <= o_act_nxt;
      o_ls_r  <= o_ls_nxt;
      o_rs_r  <= o_rs_nxt;
      o_req_r <= o_req_nxt;
      o_gr_r  <= o_gr_nxt;
      o_fin_r <= o_fin_nxt;
    end
  end

  // steering decision and sequencer update
  always_comb begin
    logic reached, turn_sel;
    logic signed [7:0] tsp, msp, rsp;
    reached        = close_r && (CMPW'(mag_r) <= CMPW'(stop_thr_r));
    turn_sel       = close_r || (CMPW'(mag_r) > CMPW'(turn_thr_r));
    tsp            = {1'b0, turn_spd_r};
    msp            = {1'b0, move_spd_r};
    rsp            = {1'b0, red};
    phase_nxt      = phase_r;
    loc_flag_nxt   = loc_flag_r;
    pend_valid_nxt = pend_valid_r;
    act_id_nxt     = act_id_r;
    last_id_nxt    = last_id_r;
    o_id_nxt       = '0;
    o_act_nxt      = ACT_NONE;
    o_ls_nxt       = '0;
    o_rs_nxt       = '0;
    o_req_nxt      = REQ_NONE;
    o_gr_nxt       = 1'b0;
    o_fin_nxt      = 1'b0;
    case (func_t'(func_r))
      FUNC_GOTO: begin
        last_id_nxt = last_id_r + 1'b1;
        if (last_id_nxt == '0) last_id_nxt = ID_WIDTH'(1);
        pend_valid_nxt = 1'b1;
        o_id_nxt       = last_id_nxt;
      end
      FUNC_TICK: begin
        case (phase_r)
          PH_REQ_BEFORE, PH_REQ_AFTER: begin
            if (loc_present_r) begin
              loc_flag_nxt = 1'b0;
              o_req_nxt    = REQ_START;
              phase_nxt    = (phase_r == PH_REQ_BEFORE) ? PH_WAIT_BEFORE : PH_WAIT_AFTER;
            end else begin
              phase_nxt    = (phase_r == PH_REQ_BEFORE) ? PH_GOTO : PH_FINISH;
            end
          end
          PH_WAIT_BEFORE: if (loc_flag_r) phase_nxt = PH_GOTO;
          PH_WAIT_AFTER:  if (loc_flag_r) phase_nxt = PH_FINISH;
          PH_GOTO: begin
            if (reached) begin
              o_act_nxt = ACT_STOP;
              phase_nxt = PH_REQ_AFTER;
            end else if (turn_sel) begin
              o_act_nxt = ACT_TURN;
              o_ls_nxt  = dh_r[AW-1] ? -tsp : tsp;
              o_rs_nxt  = dh_r[AW-1] ? tsp : -tsp;
            end else begin
              o_act_nxt = ACT_MOVE;
              o_ls_nxt  = dh_r[AW-1] ? rsp : msp;
              o_rs_nxt  = dh_r[AW-1] ? msp : rsp;
            end
          end
          PH_FINISH: begin
            o_fin_nxt  = 1'b1;
            o_id_nxt   = act_id_r;
            act_id_nxt = '0;
            phase_nxt  = PH_WAIT_CMD;
          end
          default: begin
            phase_nxt = PH_WAIT_CMD;
            if (pend_valid_r) begin
              act_id_nxt     = pend_id_r;
              pend_valid_nxt = 1'b0;
              phase_nxt      = PH_REQ_BEFORE;
            end
          end
        endcase
      end
      FUNC_QUERY: begin
        if (loc_present_r && !loc_flag_r &&
            (phase_r == PH_WAIT_BEFORE || phase_r == PH_WAIT_AFTER)) begin
          loc_flag_nxt = 1'b1;
          o_gr_nxt     = 1'b1;
          o_req_nxt    = REQ_STOP;
        end
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT_CMD;
      loc_flag_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_x_r     <= '0;
      pend_y_r     <= '0;
      pend_h_r     <= '0;
      pend_id_r    <= '0;
      act_x_r      <= '0;
      act_y_r      <= '0;
      act_h_r      <= '0;
      act_id_r     <= '0;
      last_id_r    <= '0;
    end else if (cmd.commit) begin
      phase_r      <= phase_nxt;
      loc_flag_r   <= loc_flag_nxt;
      pend_valid_r <= pend_valid_nxt;
      act_id_r     <= act_id_nxt;
      last_id_r    <= last_id_nxt;
      if (func_r == FUNC_GOTO) begin
        pend_x_r  <= tx_r;
        pend_y_r  <= ty_r;
        pend_h_r  <= th_r;
        pend_id_r <= last_id_nxt;
      end
      if (func_r == FUNC_TICK && pend_valid_r &&
          !(phase_r inside {PH_REQ_BEFORE, PH_WAIT_BEFORE, PH_GOTO,
                            PH_REQ_AFTER, PH_WAIT_AFTER, PH_FINISH})) begin
        act_x_r <= pend_x_r;
        act_y_r <= pend_y_r;
        act_h_r <= pend_h_r;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.cmd_id           = o_id_r;
  assign out_if.action           = o_act_r;
  assign out_if.left_speed       = o_ls_r;
  assign out_if.right_speed      = o_rs_r;
  assign out_if.localize_request = o_req_r;
  assign out_if.granted          = o_gr_r;
  assign out_if.finished         = o_fin_r;

endmodule

@@ sv/go_to_point_navigation_controller.sv @@
// Channel   Dir  Handshake        Payload
// in_if     in   valid / ready    func, target x/y/heading, pose x/y/heading
// out_if    out  valid / ready    cmd_id, action, speeds, localize_request, granted, finished
// cfg_if    in   valid / ready    3-bit register index, 15-bit data; ready always high
//
// The result passes through the load, square, init, rotate, error, scale and result steps,
// the rotate step being the one-iteration-per-cycle CORDIC arctangent loop; the next item
// can be accepted once the result has been committed to the output register.
// One item is in flight at a time; a result waits in the output register.
// A stalled result holds the block in its final step until out_if.ready.
// rst_n is synchronous, active low; configuration returns to its reset values.
module go_to_point_navigation_controller
  import gtp_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int ID_WIDTH     = ID_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gtp_in_if.sink    in_if,
  gtp_out_if.source out_if,
  gtp_cfg_if.sink   cfg_if
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       rdy;

  assign in_if.ready = rdy;

  gtp_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (rdy),
    .status   (status),
    .cmd      (cmd)
  );

  gtp_datapath #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_if.func),
    .in_target_x       (in_if.target_x),
    .in_target_y       (in_if.target_y),
    .in_target_heading (in_if.target_heading),
    .in_pose_x         (in_if.pose_x),
    .in_pose_y         (in_if.pose_y),
    .in_pose_heading   (in_if.pose_heading),
    .cfg_if            (cfg_if),
    .out_if            (out_if),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

@@ sv/gtp_checker.sv @@
`include "go_to_point_navigation_controller_defines.svh"

module gtp_checker
  import gtp_pkg::*;
#(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ID_WIDTH-1:0] cmd_id,
  input logic [1:0]          action,
  input logic signed [7:0]   left_speed,
  input logic signed [7:0]   right_speed,
  input logic [1:0]          localize_request,
  input logic                granted,
  input logic                finished
);

  // stalled result keeps its id
  `GTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cmd_id))

  // one item at a time: busy right after acceptance
  `GTP_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // a finish carries a real id and no motion
  `GTP_ASSERT_NOW(a_fin, clk, rst_n, out_valid && finished, cmd_id != '0 && action == ACT_NONE)

  // a grant is always paired with a stop-localize request
  `GTP_ASSERT_NOW(a_grant, clk, rst_n, out_valid && granted, localize_request == REQ_STOP)

  // speeds only move with move or turn
  `GTP_ASSERT_NOW(a_spd, clk, rst_n, out_valid && (action == ACT_NONE || action == ACT_STOP), left_speed == 8'sd0 && right_speed == 8'sd0)

endmodule

bind go_to_point_navigation_controller gtp_checker #(
  .ID_WIDTH(ID_WIDTH)
) u_gtp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .cmd_id           (out_if.cmd_id),
  .action           (out_if.action),
  .left_speed       (out_if.left_speed),
  .right_speed      (out_if.right_speed),
  .localize_request (out_if.localize_request),
  .granted          (out_if.granted),
  .finished         (out_if.finished)
);

@@ tb/sv/tb.sv @@
module tb;
  import gtp_pkg::*;

  localparam int LATENCY    = 22;
  localparam int WDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;

  gtp_in_if  #(.COORD_WIDTH(16), .ANGLE_WIDTH(16)) in_ch();
  gtp_out_if #(.ID_WIDTH(16)) out_ch();
  gtp_cfg_if cfg_ch();

  go_to_point_navigation_controller u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_if(cfg_ch.sink)
  );

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] tx, ty, th, px, py, ph;
  } nav_item_t;

  typedef struct packed {
    logic [15:0]       id;
    logic [1:0]        act;
    logic signed [7:0] ls, rs;
    logic [1:0]        req;
    logic              gr, fin;
  } nav_res_t;

  // predictor state and registers
  logic        loc_present;
  logic [11:0] dist_thr;
  logic [14:0] stop_thr, turn_thr;
  logic [6:0]  mv_spd, tn_spd;
  phase_t      nav_phase;
  logic        localized, pend_valid;
  logic signed [15:0] pend_x, pend_y, pend_h, act_x, act_y, act_h;
  logic [15:0] pend_id, act_id, last_id;

  nav_item_t pending_items[$];
  nav_res_t  expected_results[$];
  int  mismatches = 0;
  bit  quiet = 0;
  int  in_gap = 0, out_gap = 0;

  // CORDIC bearing, clockwise from +y, 16-bit binary angle
  function automatic logic [15:0] bearing16(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    longint unsigned u;
    longint tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                        333772, 166886, 83443, 41722, 20861};
    if (dx == 0 && dy == 0) return 16'h4000;
    x = dy; y = dx; z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd1 << 30;
      end else begin
        t = x; x = -y; y = t; z = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += tab[i];
      end else begin
        x -= ys; y += xs; z -= tab[i];
      end
    end
    u = (z & 64'hFFFF_FFFF) + (64'd1 << 15);
    return u[31:16];
  endfunction

  // steering decision for one tick in the goto phase; returns reached
  function automatic bit nav_steer(longint px, longint py, longint ph, ref nav_res_t r);
    longint dx, dy, mag, m, red;
    longint signed dh;
    logic [15:0] head, diff;
    bit close;
    dx = longint'(act_x) - px;
    dy = longint'(act_y) - py;
    close = 0;
    if (dx > -4096 && dx < 4096 && dy > -4096 && dy < 4096)
      close = (dx * dx + dy * dy) < longint'(dist_thr) * longint'(dist_thr);
    head = close ? act_h : bearing16(dx, dy);
    diff = head - ph[15:0];
    dh = longint'($signed(diff));
    mag = dh < 0 ? -dh : dh;
    if (close && mag <= longint'(stop_thr)) begin
      r.act = ACT_STOP;
      return 1;
    end
    if (close || mag > longint'(turn_thr)) begin
      r.act = ACT_TURN;
      r.ls = dh >= 0 ? $signed({1'b0, tn_spd}) : -$signed({1'b0, tn_spd});
      r.rs = -r.ls;
      return 0;
    end
    m = mag > 4096 ? 4096 : mag;
    red = (longint'(mv_spd) * (8192 - m)) / 8192;
    r.act = ACT_MOVE;
    r.ls = mv_spd;
    r.rs = mv_spd;
    if (dh >= 0) r.rs = red;
    else r.ls = red;
    return 0;
  endfunction

  function automatic nav_res_t predict_nav(nav_item_t it);
    nav_res_t r;
    r = '0;
    case (func_t'(it.func))
      FUNC_GOTO: begin
        last_id = last_id + 16'd1;
        if (last_id == 0) last_id = 16'd1;
        pend_id = last_id;
        pend_x = it.tx; pend_y = it.ty; pend_h = it.th;
        pend_valid = 1;
        r.id = last_id;
      end
      FUNC_TICK: begin
        case (nav_phase)
          PH_REQ_BEFORE, PH_REQ_AFTER: begin
            if (loc_present) begin
              localized = 0;
              r.req = REQ_START;
              nav_phase = (nav_phase == PH_REQ_BEFORE) ? PH_WAIT_BEFORE : PH_WAIT_AFTER;
            end else begin
              nav_phase = (nav_phase == PH_REQ_BEFORE) ? PH_GOTO : PH_FINISH;
            end
          end
          PH_WAIT_BEFORE: if (localized) nav_phase = PH_GOTO;
          PH_WAIT_AFTER:  if (localized) nav_phase = PH_FINISH;
          PH_GOTO: if (nav_steer(it.px, it.py, it.ph, r)) nav_phase = PH_REQ_AFTER;
          PH_FINISH: begin
            r.fin = 1;
            r.id = act_id;
            act_id = 0;
            nav_phase = PH_WAIT_CMD;
          end
          default: begin
            nav_phase = PH_WAIT_CMD;
            if (pend_valid) begin
              act_x = pend_x; act_y = pend_y; act_h = pend_h; act_id = pend_id;
              pend_valid = 0;
              nav_phase = PH_REQ_BEFORE;
            end
          end
        endcase
      end
      FUNC_QUERY: begin
        if (loc_present && !localized &&
            (nav_phase == PH_WAIT_BEFORE || nav_phase == PH_WAIT_AFTER)) begin
          localized = 1;
          r.gr = 1;
          r.req = REQ_STOP;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(pending_items.pop_front());
      if (in_ch.valid && !in_ch.ready) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_ch.valid <= 0;
      end else begin
        // pending_items front is next item; popped above on acceptance
        if ((in_ch.valid && in_ch.ready) ? pending_items.size() > 0
                                          : pending_items.size() > 0) begin
          in_ch.valid <= 1;
          in_ch.func <= pending_items[0].func;
          in_ch.target_x <= pending_items[0].tx;
          in_ch.target_y <= pending_items[0].ty;
          in_ch.target_heading <= pending_items[0].th;
          in_ch.pose_x <= pending_items[0].px;
          in_ch.pose_y <= pending_items[0].py;
          in_ch.pose_heading <= pending_items[0].ph;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // prediction on acceptance, monitor and sink stalls
  always @(posedge clk) begin
    nav_item_t it;
    nav_res_t  got, want;
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it = {in_ch.func, in_ch.target_x, in_ch.target_y, in_ch.target_heading,
              in_ch.pose_x, in_ch.pose_y, in_ch.pose_heading};
        expected_results.push_back(predict_nav(it));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.cmd_id, out_ch.action, out_ch.left_speed, out_ch.right_speed,
               out_ch.localize_request, out_ch.granted, out_ch.finished};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.id !== want.id) report_mismatch("cmd_id", got.id, want.id);
          if (got.act !== want.act) report_mismatch("action", got.act, want.act);
          if (got.ls !== want.ls) report_mismatch("left_speed", got.ls, want.ls);
          if (got.rs !== want.rs) report_mismatch("right_speed", got.rs, want.rs);
          if (got.req !== want.req) report_mismatch("localize_request", got.req, want.req);
          if (got.gr !== want.gr) report_mismatch("granted", got.gr, want.gr);
          if (got.fin !== want.fin) report_mismatch("finished", got.fin, want.fin);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // watchdog on stalled handshakes
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (pending_items.size() > 0 || expected_results.size() > 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  // register write through the config channel, block idle
  task automatic write_reg(cfg_idx_t idx, logic [14:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    case (idx)
      CFG_LOC_PRESENT: loc_present = val[0];
      CFG_DIST_THR:    dist_thr = val[11:0];
      CFG_STOP_THR:    stop_thr = val;
      CFG_TURN_THR:    turn_thr = val;
      CFG_MOVE_SPD:    mv_spd = val[6:0];
      CFG_TURN_SPD:    tn_spd = val[6:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic nav_item_t mk(func_t f, logic signed [15:0] a, b, c, d, e, g);
    nav_item_t it;
    it = {f, a, b, c, d, e, g};
    return it;
  endfunction

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom());
  endfunction

  // random goto run: command, then ticks near the target with queries and random items mixed in
  task automatic add_random_run(int ticks);
    logic signed [15:0] tx, ty;
    tx = ($urandom_range(0, 3) == 0) ? rnd16() : $signed(16'($urandom_range(0, 200) - 100));
    ty = ($urandom_range(0, 3) == 0) ? rnd16() : $signed(16'($urandom_range(0, 200) - 100));
    pending_items.push_back(mk(FUNC_GOTO, tx, ty, rnd16(), rnd16(), rnd16(), rnd16()));
    for (int k = 0; k < ticks; k++) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back(mk(func_t'($urandom_range(0, 3)), rnd16(), rnd16(),
                                      rnd16(), rnd16(), rnd16(), rnd16()));
        1, 2: pending_items.push_back(mk(FUNC_QUERY, rnd16(), rnd16(), rnd16(),
                                         rnd16(), rnd16(), rnd16()));
        default: pending_items.push_back(mk(FUNC_TICK, rnd16(), rnd16(), rnd16(),
            tx + $signed(16'($urandom_range(0, 40) - 20)),
            ty + $signed(16'($urandom_range(0, 40) - 20)),
            ($urandom_range(0, 1) ? rnd16() : 16'($urandom_range(0, 4000) - 2000))));
      endcase
    end
  endtask

  initial begin
    int settings;
    loc_present = 0; dist_thr = 10; stop_thr = 1820; turn_thr = 5461;
    mv_spd = 12; tn_spd = 12;
    nav_phase = PH_WAIT_CMD; localized = 0; pend_valid = 0;
    pend_x = 0; pend_y = 0; pend_h = 0; pend_id = 0;
    act_x = 0; act_y = 0; act_h = 0; act_id = 0; last_id = 0;
    rst_n = 0;
    in_ch.valid = 0; in_ch.func = FUNC_NONE;
    in_ch.target_x = 0; in_ch.target_y = 0; in_ch.target_heading = 0;
    in_ch.pose_x = 0; in_ch.pose_y = 0; in_ch.pose_heading = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = CFG_LOC_PRESENT; cfg_ch.data = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults, no localizer; extremes, replaced command, func 3
    pending_items.push_back(mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_NONE, -1, -1, -1, -1, -1, -1));
    pending_items.push_back(mk(FUNC_GOTO, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 0, 0, 0));
    pending_items.push_back(mk(FUNC_GOTO, 100, 0, -16'sh8000, 0, 0, 0));
    for (int k = 0; k < 4; k++)
      pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, -16'sh8000, 16'sh7FFF, 16'sh7FFF));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 16'sh4000));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 16'sh3000));
    // close: heading error of exactly half a turn, then aligned
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 100, 0, 16'sh0000));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 100, 0, -16'sh8000));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // localizer attached, zero distance threshold: zero-offset bearing
    write_reg(CFG_LOC_PRESENT, 1);
    write_reg(CFG_DIST_THR, 0);
    pending_items.push_back(mk(FUNC_GOTO, 5, 5, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(FUNC_TICK, 0, 0, 0, 5, 5, 0));
    wait_drained();

    // random phases across register settings
    for (settings = 0; settings < 8; settings++) begin
      write_reg(CFG_LOC_PRESENT, $urandom_range(0, 1));
      write_reg(CFG_DIST_THR, settings == 0 ? 15'd4095 : 15'($urandom_range(0, 60)));
      write_reg(CFG_STOP_THR, settings == 1 ? 15'd16384 :
                settings == 2 ? 15'd0 : 15'($urandom_range(0, 16384)));
      write_reg(CFG_TURN_THR, settings == 1 ? 15'd0 :
                settings == 2 ? 15'd16384 : 15'($urandom_range(0, 16384)));
      write_reg(CFG_MOVE_SPD, settings == 3 ? 15'd0 :
                settings == 4 ? 15'd127 : 15'($urandom_range(0, 127)));
      write_reg(CFG_TURN_SPD, settings == 3 ? 15'd127 :
                settings == 4 ? 15'd0 : 15'($urandom_range(0, 127)));
      if (settings == 7) quiet = 1;
      for (int r = 0; r < 4; r++) add_random_run($urandom_range(6, 14));
      wait_drained();
    end

    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
